// ===== src/multi_phase_sine_generator_assert.svh =====
// ----------------------------------------------------------------------------
// multi_phase_sine_generator_assert
// Assertion macros for the sine generator checker.
// ----------------------------------------------------------------------------
// Both macros sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef MULTI_PHASE_SINE_GENERATOR_ASSERT_SVH
`define MULTI_PHASE_SINE_GENERATOR_ASSERT_SVH

// Same-cycle implication: the consequent may carry its own fixed delay.
`define MPSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication.
`define MPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsg_pkg
// Shared types, constants and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package mpsg_pkg;

	localparam int TBL_BITS = 10;                   // log2 of quarter-wave steps
	localparam int SMP_BITS = 16;                   // signed sample width
	localparam int TBL_LEN  = (1 << TBL_BITS) + 1;  // both quarter ends
	localparam int ADDR_W   = TBL_BITS + 1;
	localparam int MAG_W    = SMP_BITS - 1;         // sample magnitude width

	localparam int N_AXES   = 6;
	localparam int AXIS_W   = 3;
	localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(N_AXES - 1);

	localparam int PHASE_W  = 16;
	localparam int FREQ_W   = 15;
	localparam int AMP_W    = 15;
	localparam int TIME_W   = 32;
	localparam int OUT_W    = 16;
	localparam int CFG_W    = 16;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		REG_FREQUENCY   = 2'd0,
		REG_AMPLITUDE   = 2'd1,
		REG_PHASE_STEP  = 2'd2,
		REG_AXIS_ENABLE = 2'd3
	} reg_idx_t;

	// One axis issued into the sine pipeline.
	typedef struct packed {
		logic               vld;
		logic               en;
		logic [AXIS_W-1:0]  axis;
		logic [PHASE_W-1:0] phase;
	} issue_t;

	// One finished axis value leaving the pipeline.
	typedef struct packed {
		logic                    vld;
		logic [AXIS_W-1:0]       axis;
		logic signed [OUT_W-1:0] value;
	} axis_res_t;

	typedef logic [MAG_W-1:0] sine_tbl_t [TBL_LEN];

	// Quarter-wave table: sin(pi/2 * i / 2^TBL_BITS) scaled to full scale,
	// from a Q30 Taylor series. Elaboration-time only.
	function automatic sine_tbl_t build_sine_table();
		sine_tbl_t   tbl;
		logic [63:0] full;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		full = (64'd1 << (SMP_BITS - 1)) - 64'd1;
		for (int i = 0; i < TBL_LEN; i++) begin
			x = (HALF_PI_Q30 * 64'(i) + (64'd1 << (TBL_BITS - 1))) >> TBL_BITS;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 13; n++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (64'(sum) * full + (64'd1 << 29)) >> 30;
			if (v > full) begin
				v = full;
			end
			tbl[i] = v[MAG_W-1:0];
		end
		return tbl;
	endfunction

endpackage

// ===== src/mpsg_seq.sv =====
// ----------------------------------------------------------------------------
// mpsg_seq
// Base phase multiply and per-axis phase sequencer.
// ----------------------------------------------------------------------------
module mpsg_seq
	import mpsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [TIME_W-1:0]  time_stamp,
	input  logic [FREQ_W-1:0]  frequency,
	input  logic [PHASE_W-1:0] phase_step,
	input  logic [N_AXES-1:0]  axis_enable,
	output issue_t             issue
);

	localparam int PROD_W = TIME_W + FREQ_W;

	logic [PROD_W-1:0]  prod;
	logic [PHASE_W-1:0] base;
	logic               active_q;
	logic [AXIS_W-1:0]  axis_q;
	logic [PHASE_W-1:0] phase_q;
	logic               accept;

	// frequency * time in 1/(65536*1024) turn; keep bits 10.. as the phase
	assign prod   = PROD_W'(frequency) * PROD_W'(time_stamp);
	assign base   = prod[PHASE_W+9:10];
	assign busy   = active_q && (axis_q != LAST_AXIS);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			axis_q   <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			axis_q   <= '0;
		end else if (active_q) begin
			axis_q <= axis_q + 1'b1;
			if (axis_q == LAST_AXIS) begin
				active_q <= 1'b0;
			end
		end
	end

	// advance phase by one step per axis, wrapping modulo one turn
	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q <= base;
		end else if (active_q) begin
			phase_q <= phase_q + phase_step;
		end
	end

	always_comb begin
		issue.vld   = active_q;
		issue.en    = axis_enable[axis_q];
		issue.axis  = axis_q;
		issue.phase = phase_q;
	end

endmodule

// ===== src/mpsg_sine.sv =====
// ----------------------------------------------------------------------------
// mpsg_sine
// Four-stage sine pipeline: address fold, table read, scale, sign.
// ----------------------------------------------------------------------------
module mpsg_sine
	import mpsg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  issue_t           issue,
	input  logic [AMP_W-1:0] amplitude,
	output axis_res_t        res
);

	localparam int        IDX_SHIFT = 14 - TBL_BITS;
	localparam logic [14:0] IDX_HALF = (IDX_SHIFT == 0) ? 15'd0 : 15'(1 << (IDX_SHIFT - 1));
	localparam logic [ADDR_W-1:0] IDX_TOP = ADDR_W'(1 << TBL_BITS);
	localparam int        PROD_W = MAG_W + AMP_W;
	localparam logic [PROD_W:0] RND = (PROD_W + 1)'(1 << (SMP_BITS - 2));
	localparam sine_tbl_t SineRom = build_sine_table();

	logic [14:0]        idx_sum;
	logic [ADDR_W-1:0]  idx;
	logic [ADDR_W-1:0]  addr;
	logic [PROD_W:0]    prod;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               en_s1, en_s2, en_s3;
	logic               neg_s1, neg_s2, neg_s3;
	logic [AXIS_W-1:0]  axis_s1, axis_s2, axis_s3, axis_s4;
	logic [ADDR_W-1:0]  addr_s1;
	logic [MAG_W-1:0]   sample_s2;
	logic [OUT_W-1:0]   mag_s3;
	logic [OUT_W-1:0]   value_s4;

	// round to the nearest table step, mirror in odd quadrants
	assign idx_sum = {1'b0, issue.phase[13:0]} + IDX_HALF;
	assign idx     = idx_sum[14:IDX_SHIFT];
	assign addr    = issue.phase[14] ? (IDX_TOP - idx) : idx;

	assign prod = (PROD_W + 1)'(sample_s2) * (PROD_W + 1)'(amplitude) + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= issue.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: table address
		en_s1   <= issue.en;
		neg_s1  <= issue.phase[15];
		axis_s1 <= issue.axis;
		addr_s1 <= addr;
		// stage 2: table read
		en_s2     <= en_s1;
		neg_s2    <= neg_s1;
		axis_s2   <= axis_s1;
		sample_s2 <= SineRom[addr_s1];
		// stage 3: scale by amplitude, round half away from zero
		en_s3   <= en_s2;
		neg_s3  <= neg_s2;
		axis_s3 <= axis_s2;
		mag_s3  <= prod[PROD_W:SMP_BITS-1];
		// stage 4: apply sign, drop disabled axes
		axis_s4 <= axis_s3;
		if (!en_s3) begin
			value_s4 <= '0;
		end else if (neg_s3) begin
			value_s4 <= OUT_W'(0) - mag_s3;
		end else begin
			value_s4 <= mag_s3;
		end
	end

	always_comb begin
		res.vld   = vld_s4;
		res.axis  = axis_s4;
		res.value = $signed(value_s4);
	end

endmodule

// ===== src/multi_phase_sine_generator.sv =====
// ----------------------------------------------------------------------------
// multi_phase_sine_generator
// Six-axis sine source: one timestamp in, six phase-shifted positions out.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------
//  command   start / busy           time_stamp (32b, 1/65536 s)
//  result    done (one-cycle pulse) surge/sway/heave/roll/pitch/yaw_out
//  config    cfg_valid / cfg_ready  cfg_index (2b), cfg_data (16b)
//
// A word is taken at every edge with start high and busy low; the sequencer
// feeds the six axes into the shared sine pipeline one per cycle. The next
// word is taken in the cycle the last axis of the current word is issued.
// done is registered from the last axis leaving the sine pipeline, and the
// result word is taken at the edge that ends the done cycle; the six
// outputs are valid only in the done cycle. Reset clears the sequencer,
// the pipeline valids and loads the register defaults; the receiver cannot
// stall, so there is no back-pressure. cfg_ready is always high.
//
module multi_phase_sine_generator
	import mpsg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// command
	input  logic                    start,
	output logic                    busy,
	input  logic [TIME_W-1:0]       time_stamp,
	// result
	output logic                    done,
	output logic signed [OUT_W-1:0] surge_out,
	output logic signed [OUT_W-1:0] sway_out,
	output logic signed [OUT_W-1:0] heave_out,
	output logic signed [OUT_W-1:0] roll_out,
	output logic signed [OUT_W-1:0] pitch_out,
	output logic signed [OUT_W-1:0] yaw_out,
	// configuration
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	logic [FREQ_W-1:0]  frequency_q;
	logic [AMP_W-1:0]   amplitude_q;
	logic [PHASE_W-1:0] phase_step_q;
	logic [N_AXES-1:0]  axis_enable_q;

	issue_t             issue;
	axis_res_t          res;

	logic signed [OUT_W-1:0] pos_q [N_AXES];
	logic                    done_q;

	assign cfg_ready = 1'b1;

	// Configuration registers; the sender must write them only while the block
	// is idle, so no word in flight sees a change. The block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frequency_q   <= FREQ_W'(1024);
			amplitude_q   <= AMP_W'(12800);
			phase_step_q  <= PHASE_W'(10923);
			axis_enable_q <= N_AXES'(7);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FREQUENCY:   frequency_q   <= cfg_data[FREQ_W-1:0];
				REG_AMPLITUDE:   amplitude_q   <= cfg_data[AMP_W-1:0];
				REG_PHASE_STEP:  phase_step_q  <= cfg_data[PHASE_W-1:0];
				REG_AXIS_ENABLE: axis_enable_q <= cfg_data[N_AXES-1:0];
				default: ;
			endcase
		end
	end

	// Base phase and axis sequencing: one axis enters the pipeline per cycle.
	mpsg_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.time_stamp  (time_stamp),
		.frequency   (frequency_q),
		.phase_step  (phase_step_q),
		.axis_enable (axis_enable_q),
		.issue       (issue)
	);

	// Shared table lookup and amplitude scaling.
	mpsg_sine u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.amplitude (amplitude_q),
		.res       (res)
	);

	// Collect axis values. The next word's first axis lands in the cycle after
	// done is raised, so the outputs are stable for the whole done cycle.
	always_ff @(posedge clk) begin
		if (res.vld) begin
			pos_q[res.axis] <= res.value;
		end
	end

	// Raise done once the last axis is in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.vld && (res.axis == LAST_AXIS);
		end
	end

	assign done      = done_q;
	assign surge_out = pos_q[0];
	assign sway_out  = pos_q[1];
	assign heave_out = pos_q[2];
	assign roll_out  = pos_q[3];
	assign pitch_out = pos_q[4];
	assign yaw_out   = pos_q[5];

endmodule

// ===== src/mpsg_checker.sv =====
// ----------------------------------------------------------------------------
// mpsg_checker
// Port-level timing checks for the sine generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_phase_sine_generator_assert.svh"

module mpsg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	`MPSG_ASSERT_NOW(a_done_latency, start && !busy, ##11 done, "done missing 11 cycles after accept")
	`MPSG_ASSERT_NOW(a_done_cause, done, $past(start && !busy, 11), "done without matching accept")
	`MPSG_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low right after accept")
	`MPSG_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")

endmodule

bind multi_phase_sine_generator mpsg_checker u_mpsg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// ===== bench/multi_phase_sine_generator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_phase_sine_generator_test
// Self-checking bench for the six-axis sine source. It writes the registers
// between phases, feeds timestamps with random gaps, predicts all six axis
// positions per word and compares each done word field by field.
// ----------------------------------------------------------------------------
module multi_phase_sine_generator_test;
	import mpsg_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 5;
	// A word waits at most the longest sender gap plus the result latency;
	// allow many times that with nothing moving.
	localparam int IDLE_LIMIT      = 2000;
	localparam int TAIL_CYCLES     = 20;   // outlast the pipeline
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 100;
	localparam int FRAC_BITS       = 14;   // phase bits below the quadrant
	// pi/2 in Q30
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	// With the reset frequency the phase equals the low 16 bits of the
	// timestamp: walk zero, both quadrant edges and the rounding into the
	// top table entry, plus the ends of the timestamp range.
	localparam logic [TIME_W-1:0] DEFAULT_STAMPS [10] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_3FF7, 32'h0000_3FF8,
		32'h0000_4000, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_C000,
		32'h8000_FFFF, 32'h5555_AAAA
	};
	localparam logic [TIME_W-1:0] EDGE_STAMPS [3] = '{
		32'hFFFF_FFFF, 32'h0000_0001, 32'h9E37_79B9
	};

	// Index k holds axis k: surge, sway, heave, roll, pitch, yaw.
	typedef logic [N_AXES-1:0][OUT_W-1:0] position_set_t;

	// Register image, quarter-wave table and the positions still owed.
	class position_board;
		logic [FREQ_W-1:0]  freq;
		logic [AMP_W-1:0]   amp;
		logic [PHASE_W-1:0] step;
		logic [N_AXES-1:0]  axis_on;
		logic [MAG_W-1:0]   quarter_wave [TBL_LEN];
		position_set_t      pending_positions [$];
		string              axis_name [N_AXES];
		int                 failures;

		function new();
			axis_name = '{"surge", "sway", "heave", "roll", "pitch", "yaw"};
			failures  = 0;
			freq      = FREQ_W'(1024);
			amp       = AMP_W'(12800);
			step      = PHASE_W'(10923);
			axis_on   = N_AXES'(7);
			fill_quarter_wave();
		endfunction

		// Q30 Taylor series for each table point, scaled to full scale.
		function void fill_quarter_wave();
			longint unsigned full_scale, ang, ang_sq, term, level;
			longint          acc;
			full_scale = (64'd1 << (SMP_BITS - 1)) - 64'd1;
			for (int i = 0; i < TBL_LEN; i++) begin
				ang    = (QUARTER_TURN_Q30 * 64'(i) + (64'd1 << (TBL_BITS - 1))) >> TBL_BITS;
				ang_sq = (ang * ang) >> 30;
				term   = ang;
				acc    = longint'(ang);
				for (int n = 1; n <= 13; n++) begin
					term = (term * ang_sq) >> 30;
					term = term / 64'((2 * n) * (2 * n + 1));
					acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
				end
				if (acc < 0) begin
					acc = 0;
				end
				level = (64'(acc) * full_scale + (64'd1 << 29)) >> 30;
				if (level > full_scale) begin
					level = full_scale;
				end
				quarter_wave[i] = level[MAG_W-1:0];
			end
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FREQUENCY:   freq    = data[FREQ_W-1:0];
				REG_AMPLITUDE:   amp     = data[AMP_W-1:0];
				REG_PHASE_STEP:  step    = data[PHASE_W-1:0];
				REG_AXIS_ENABLE: axis_on = data[N_AXES-1:0];
				default: ;
			endcase
		endfunction

		// Fold the phase into the first quadrant, look up, scale with
		// round-half-away, then restore the sign for the lower half turn.
		function logic [OUT_W-1:0] level_at(logic [PHASE_W-1:0] ph);
			int unsigned     slot;
			longint unsigned mag;
			slot = (int'(ph[FRAC_BITS-1:0]) + ((1 << (FRAC_BITS - TBL_BITS)) >> 1))
				>> (FRAC_BITS - TBL_BITS);
			if (ph[FRAC_BITS]) begin
				slot = (1 << TBL_BITS) - slot;
			end
			mag = (64'(quarter_wave[slot]) * 64'(amp) + (64'd1 << (SMP_BITS - 2)))
				>> (SMP_BITS - 1);
			if (ph[PHASE_W-1]) begin
				return OUT_W'(64'd0 - mag);
			end
			return OUT_W'(mag);
		endfunction

		function void note_stamp(logic [TIME_W-1:0] stamp);
			position_set_t      want;
			longint unsigned    prod;
			logic [PHASE_W-1:0] base;
			prod = 64'(freq) * 64'(stamp);
			base = prod[PHASE_W+9:10];
			for (int k = 0; k < N_AXES; k++) begin
				want[k] = axis_on[k] ? level_at(base + PHASE_W'(step * k)) : '0;
			end
			pending_positions.push_back(want);
		endfunction

		function void check_positions(position_set_t seen);
			position_set_t want;
			if (pending_positions.size() == 0) begin
				failures++;
				$display("%0t: done with no timestamp outstanding: expected none, got %h",
					$time, seen);
				return;
			end
			want = pending_positions.pop_front();
			for (int k = 0; k < N_AXES; k++) begin
				if (seen[k] !== want[k]) begin
					failures++;
					$display("%0t: %s_out mismatch: expected %0d, got %0d", $time,
						axis_name[k], $signed(want[k]), $signed(seen[k]));
				end
			end
		endfunction
	endclass

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    start      = 1'b0;
	logic [TIME_W-1:0]       time_stamp = '0;
	logic                    cfg_valid  = 1'b0;
	logic [1:0]              cfg_index  = '0;
	logic [CFG_W-1:0]        cfg_data   = '0;
	logic                    busy;
	logic                    done;
	logic                    cfg_ready;
	logic signed [OUT_W-1:0] surge_out, sway_out, heave_out;
	logic signed [OUT_W-1:0] roll_out, pitch_out, yaw_out;

	position_board board;

	multi_phase_sine_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.time_stamp (time_stamp),
		.done       (done),
		.surge_out  (surge_out),
		.sway_out   (sway_out),
		.heave_out  (heave_out),
		.roll_out   (roll_out),
		.pitch_out  (pitch_out),
		.yaw_out    (yaw_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap(bit burst);
		int roll;
		if (burst) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// Favor the stated range, hit both ends often, and sometimes write raw
	// 16-bit data so the bits above each register's width toggle too.
	function automatic logic [CFG_W-1:0] pick_reg_value(reg_idx_t idx);
		logic [CFG_W-1:0] lo, hi;
		case (idx)
			REG_FREQUENCY: begin
				lo = 16'd102;
				hi = 16'd20480;
			end
			REG_AMPLITUDE: begin
				lo = 16'd0;
				hi = 16'd25600;
			end
			REG_PHASE_STEP: begin
				lo = 16'd0;
				hi = 16'd32768;
			end
			default: begin
				lo = 16'd0;
				hi = 16'd63;
			end
		endcase
		case ($urandom_range(0, 7))
			0:       return lo;
			1:       return hi;
			2:       return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_stamp();
		logic [TIME_W-1:0] stamp;
		stamp = $urandom;
		case ($urandom_range(0, 9))
			0:       return TIME_W'($urandom_range(0, 255));
			1:       return ~TIME_W'($urandom_range(0, 255));
			2: begin
				// land near a quadrant edge of the low phase bits
				stamp[FRAC_BITS-1:0] = 14'h3FF8 + 14'($urandom_range(0, 15));
				return stamp;
			end
			default: return stamp;
		endcase
	endfunction

	// Hold start with the timestamp until an edge with busy low takes the
	// word; drop start only if a gap follows, so start never gets two
	// updates in one step.
	task automatic send_stamp(logic [TIME_W-1:0] stamp, int gap);
		start      <= 1'b1;
		time_stamp <= stamp;
		do @(posedge clk); while (busy);
		board.note_stamp(stamp);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Leave cfg_valid up across back-to-back writes; apply_setting drops it.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
	endtask

	task automatic apply_setting(logic [CFG_W-1:0] f, logic [CFG_W-1:0] a,
		logic [CFG_W-1:0] s, logic [CFG_W-1:0] e);
		write_reg(REG_FREQUENCY, f);
		write_reg(REG_AMPLITUDE, a);
		write_reg(REG_PHASE_STEP, s);
		write_reg(REG_AXIS_ENABLE, e);
		cfg_valid <= 1'b0;
	endtask

	// Drop start and wait until every predicted word has come back; every
	// timestamp gives a result, so the pipeline is empty after that.
	task automatic settle_idle();
		start <= 1'b0;
		while (board.pending_positions.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Take each done word at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_positions({yaw_out, pitch_out, roll_out, heave_out, sway_out, surge_out});
		end
	end

	// Count cycles with no word moving on any channel.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("** multi_phase_sine_generator: FAILED **");
		$finish;
	end

	initial begin : stimulus
		bit burst;
		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: phase walk through the quadrant edges, axes 3..5 off.
		foreach (DEFAULT_STAMPS[i]) begin
			send_stamp(DEFAULT_STAMPS[i], pick_gap(1'b0));
		end
		settle_idle();

		// Low frequency, full amplitude, half-turn step, all axes on.
		apply_setting(16'd102, 16'd25600, 16'd32768, 16'd63);
		foreach (EDGE_STAMPS[i]) begin
			send_stamp(EDGE_STAMPS[i], pick_gap(1'b0));
		end
		settle_idle();

		// High frequency with zero amplitude, zero step, every axis off.
		apply_setting(16'd20480, 16'd0, 16'd0, 16'd0);
		foreach (EDGE_STAMPS[i]) begin
			send_stamp(EDGE_STAMPS[i], pick_gap(1'b0));
		end
		settle_idle();

		// All-ones data: registers above their range, upper bits masked off.
		apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		foreach (EDGE_STAMPS[i]) begin
			send_stamp(EDGE_STAMPS[i], pick_gap(1'b0));
		end
		settle_idle();

		// Zero frequency freezes the base phase; alternate axes enabled.
		apply_setting(16'd0, 16'd25600, 16'd16384, 16'b010101);
		foreach (EDGE_STAMPS[i]) begin
			send_stamp(EDGE_STAMPS[i], pick_gap(1'b0));
		end

		// Random settings, each followed by a batch of random timestamps;
		// every third batch runs back-to-back.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle_idle();
			apply_setting(pick_reg_value(REG_FREQUENCY), pick_reg_value(REG_AMPLITUDE),
				pick_reg_value(REG_PHASE_STEP), pick_reg_value(REG_AXIS_ENABLE));
			burst = (ph % 3 == 2);
			repeat (WORDS_PER_PHASE) begin
				send_stamp(pick_stamp(), pick_gap(burst));
			end
		end

		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.pending_positions.size() == 0) begin
			$display("** multi_phase_sine_generator: PASSED **");
		end else begin
			$display("** multi_phase_sine_generator: FAILED **");
		end
		$finish;
	end

endmodule
